FILE: rtl/core/mwm_pkg.sv
// Shared widths, codes and pipeline bus types for the mecanum wheel mixer.
package mwm_pkg;

   localparam int FRAC_BITS  = 14;
   localparam int DUTY_BITS  = 8;
   localparam int NUM_WHEELS = 4;

   localparam int IN_W     = 16;                      // command component width
   localparam int SUM_W    = IN_W + 2;                // signed three-term sum
   localparam int MAG_W    = IN_W + 1;                // magnitude of a sum
   localparam int SL_W     = 8;                       // speed limit register
   localparam int PROD_W   = MAG_W + SL_W;            // |sum| * speed limit
   localparam int Q_W      = DUTY_BITS;               // quotient bits
   localparam int DEN_SH_W = MAG_W + DUTY_BITS - 1;   // divisor aligned to top bit

   localparam logic [MAG_W-1:0] UNIT_VAL       = MAG_W'(1) << FRAC_BITS;
   localparam logic [SL_W-1:0]  SPEED_LIMIT_RST = '1;

   typedef enum logic [1:0] {
      DIR_OFF = 2'd0,
      DIR_FWD = 2'd1,
      DIR_REV = 2'd2
   } dir_type;

   typedef struct packed {
      logic [PROD_W-1:0] rem;   // partial remainder
      logic [Q_W-1:0]    quo;   // quotient bits so far
      logic              neg;   // wheel sum was negative
   } lane_type;

   typedef struct packed {
      logic                         valid;
      logic [DEN_SH_W-1:0]          den_sh;
      lane_type [NUM_WHEELS-1:0]    lane;
   } div_bus_type;

endpackage

FILE: rtl/core/mwm_front.sv
// Front end: wheel sums and magnitudes, then peak, divisor and scaling product.
module mwm_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             valid_in,
   input  logic [mwm_pkg::IN_W-1:0]         vel_forward,
   input  logic [mwm_pkg::IN_W-1:0]         vel_sideways,
   input  logic [mwm_pkg::IN_W-1:0]         vel_rotate,
   input  logic [mwm_pkg::SL_W-1:0]         speed_limit,
   output mwm_pkg::div_bus_type             bus_out
);

   logic signed [mwm_pkg::SUM_W-1:0] x_ext, y_ext, w_ext;
   logic signed [mwm_pkg::SUM_W-1:0] sum_in [mwm_pkg::NUM_WHEELS];

   logic                              s1_valid_ff;
   logic [mwm_pkg::MAG_W-1:0]         mag_in [mwm_pkg::NUM_WHEELS];
   logic [mwm_pkg::MAG_W-1:0]         mag_ff [mwm_pkg::NUM_WHEELS];
   logic [mwm_pkg::NUM_WHEELS-1:0]    neg_in, neg_ff;

   logic [mwm_pkg::MAG_W-1:0]         peak_a, peak_b, peak, den;
   mwm_pkg::div_bus_type              bus_in, bus_ff;

   // stage 1: FL=x+y+w, FR=x-y-w, RL=x-y+w, RR=x+y-w
   always_comb begin
      x_ext = {{2{vel_forward[mwm_pkg::IN_W-1]}},  vel_forward};
      y_ext = {{2{vel_sideways[mwm_pkg::IN_W-1]}}, vel_sideways};
      w_ext = {{2{vel_rotate[mwm_pkg::IN_W-1]}},   vel_rotate};
      sum_in[0] = x_ext + y_ext + w_ext;
      sum_in[1] = x_ext - y_ext - w_ext;
      sum_in[2] = x_ext - y_ext + w_ext;
      sum_in[3] = x_ext + y_ext - w_ext;
      for (int k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
         neg_in[k] = sum_in[k][mwm_pkg::SUM_W-1];
         mag_in[k] = neg_in[k] ? mwm_pkg::MAG_W'(-sum_in[k])
                               : mwm_pkg::MAG_W'(sum_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   // stage 2: divisor is the peak magnitude, floored at 1.0
   always_comb begin
      peak_a = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
      peak_b = (mag_ff[2] > mag_ff[3]) ? mag_ff[2] : mag_ff[3];
      peak   = (peak_a > peak_b) ? peak_a : peak_b;
      den    = (peak > mwm_pkg::UNIT_VAL) ? peak : mwm_pkg::UNIT_VAL;

      bus_in.valid  = s1_valid_ff;
      bus_in.den_sh = {den, {(mwm_pkg::DUTY_BITS-1){1'b0}}};
      for (int k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
         bus_in.lane[k].rem = mwm_pkg::PROD_W'(mag_ff[k]) * mwm_pkg::PROD_W'(speed_limit);
         bus_in.lane[k].quo = '0;
         bus_in.lane[k].neg = neg_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else if (en) begin
         bus_ff <= bus_in;
      end
   end

   assign bus_out = bus_ff;

endmodule

FILE: rtl/core/mwm_div_stage.sv
// One restoring-division step: one quotient bit for all four wheels.
module mwm_div_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  mwm_pkg::div_bus_type bus_in,
   output mwm_pkg::div_bus_type bus_out
);

   mwm_pkg::div_bus_type bus_nx_in, bus_ff;
   logic [mwm_pkg::PROD_W-1:0] den_cmp;
   logic                       take;

   always_comb begin
      bus_nx_in        = bus_in;
      den_cmp          = mwm_pkg::PROD_W'(bus_in.den_sh);
      bus_nx_in.den_sh = bus_in.den_sh >> 1;
      for (int k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
         take = (bus_in.lane[k].rem >= den_cmp);
         bus_nx_in.lane[k].rem = take ? (bus_in.lane[k].rem - den_cmp) : bus_in.lane[k].rem;
         bus_nx_in.lane[k].quo = {bus_in.lane[k].quo[mwm_pkg::Q_W-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else if (en) begin
         bus_ff <= bus_nx_in;
      end
   end

   assign bus_out = bus_ff;

endmodule

FILE: rtl/core/mecanum_wheel_mixer_unit.sv
// Mecanum wheel mixer top level: command in, four wheel duty/direction pairs out.
//
// Usage
//   req_*  : one motion request per beat (forward, sideways, rotation, Q1.14).
//   rsp_*  : one result per request, four duty magnitudes and bridge codes.
//   csr_*  : speed limit register; write it only while the block is empty.
// Pipeline: two front-end stages, eight division stages, one output
//   register between request acceptance and rsp_tvalid.
// Throughput: one request per cycle while no result is held at the output;
//   the eight-stage divider, one quotient bit per stage, sets the depth and
//   every stage takes a new request each cycle unless stalled.
// Reset (synchronous, active high) empties the pipeline and sets the speed
//   limit to 255.
// Stall: when rsp_tready is low with a result waiting, every stage holds and
//   req_tready drops in the same cycle; nothing is lost or repeated. All
//   stages move together, so bubbles are carried along, not squeezed out.
// Scaling: wheel = |sum| * speed_limit / max(peak |sum|, 1.0), truncated.
//   The quotient can never exceed 255, so no clamp stage is needed.
module mecanum_wheel_mixer_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // vel_forward[15:0], vel_sideways[31:16], vel_rotate[47:32]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // duty_front_left[7:0], dir_front_left[9:8],
                                    // duty_front_right[17:10], dir_front_right[19:18],
                                    // duty_rear_left[27:20], dir_rear_left[29:28],
                                    // duty_rear_right[37:30], dir_rear_right[39:38]
   // speed limit register
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   logic                         en;
   logic [mwm_pkg::SL_W-1:0]     speed_limit_ff;
   mwm_pkg::div_bus_type         div_bus [mwm_pkg::Q_W+1];

   logic                         rsp_valid_ff;
   logic [39:0]                  rsp_data_in, rsp_data_ff;
   mwm_pkg::dir_type             dir_in [mwm_pkg::NUM_WHEELS];

   // whole pipeline advances unless a result is held at the output
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff <= mwm_pkg::SPEED_LIMIT_RST;
      end else if (csr_we) begin
         speed_limit_ff <= csr_wdata;
      end
   end

   mwm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .valid_in     (req_tvalid),
      .vel_forward  (req_tdata[15:0]),
      .vel_sideways (req_tdata[31:16]),
      .vel_rotate   (req_tdata[47:32]),
      .speed_limit  (speed_limit_ff),
      .bus_out      (div_bus[0])
   );

   // quotient bits MSB first, divisor shifted right one place per stage
   for (genvar g = 0; g < mwm_pkg::Q_W; g++) begin : g_div
      mwm_div_stage u_div (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .bus_in  (div_bus[g]),
         .bus_out (div_bus[g+1])
      );
   end

   // zero quotient means bridge off, even for a small non-zero sum
   always_comb begin
      for (int k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
         if (div_bus[mwm_pkg::Q_W].lane[k].quo == '0) begin
            dir_in[k] = mwm_pkg::DIR_OFF;
         end else if (div_bus[mwm_pkg::Q_W].lane[k].neg) begin
            dir_in[k] = mwm_pkg::DIR_REV;
         end else begin
            dir_in[k] = mwm_pkg::DIR_FWD;
         end
         rsp_data_in[k*10 +: 8]     = div_bus[mwm_pkg::Q_W].lane[k].quo;
         rsp_data_in[k*10 + 8 +: 2] = dir_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_bus[mwm_pkg::Q_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
